>>> rtl/core/tbpe_pkg.sv
package tbpe_pkg;

    localparam int NAME_LENGTH_DEF = 9;
    localparam int NAME_IDX_W      = 4;
    localparam int PERIOD_W        = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_WITH_FILENAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_PERIOD    = 2'd2;

    // bit slots per byte: eight data bits plus the dummy zero bit
    localparam logic [3:0] BIT_SLOTS   = 4'd9;
    // pulse counter loads: pulses + gap + one for the opening zero period
    localparam logic [4:0] PULSES_ONE  = 5'd19;
    localparam logic [4:0] PULSES_ZERO = 5'd9;
    localparam logic [4:0] PULSES_GAP  = 5'd1;

    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_NAME  = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       start_req;
        logic [7:0] offered_byte;
        logic       byte_available;
    } t_in_item;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                period_valid;
        logic                byte_taken;
        logic                end_of_data;
    } t_out_item;

    typedef struct packed {
        logic                with_filename;
        logic [PERIOD_W-1:0] pulse_period;
        logic [PERIOD_W-1:0] gap_period;
    } t_cfg;

    // fixed filename; entries past the table read as zero
    function automatic logic [7:0] name_byte(input logic [NAME_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h54; // T
            4'd1:    b = 8'h5A; // Z
            4'd2:    b = 8'h58; // X
            4'd3:    b = 8'h44; // D
            4'd4:    b = 8'h55; // U
            4'd5:    b = 8'h49; // I
            4'd6:    b = 8'h4E; // N
            4'd7:    b = 8'h4F; // O
            4'd8:    b = 8'h9D;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/tbpe_if.sv
interface tbpe_in_if import tbpe_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tbpe_out_if import tbpe_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tbpe_cfg_if import tbpe_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/core/tbpe_core.sv
module tbpe_core import tbpe_pkg::*; #(
    parameter int NAME_LENGTH = NAME_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_phase                r_phase, n_phase;
    logic [NAME_IDX_W-1:0] r_name, n_name;
    logic [3:0]            r_bits, n_bits;
    logic [4:0]            r_pulses, n_pulses;
    logic [7:0]            r_shift, n_shift;

    logic       load;
    logic       run;
    logic [7:0] ld_byte;
    logic [7:0] w_shift;
    logic [3:0] w_bits;
    logic [4:0] w_pulses;

    always_comb begin
        n_phase  = r_phase;
        n_name   = r_name;
        n_bits   = r_bits;
        n_pulses = r_pulses;
        n_shift  = r_shift;
        o_result = '0;
        load     = 1'b0;
        run      = 1'b0;
        ld_byte  = '0;

        if (i_item.start_req || r_phase == PH_START) begin
            n_name   = '0;
            n_bits   = '0;
            n_pulses = '0;
            n_shift  = '0;
            n_phase  = i_cfg.with_filename ? PH_NAME : PH_DATA;
        end else begin
            unique case (r_phase)
                PH_NAME: begin
                    if (r_bits == '0 && r_name >= NAME_IDX_W'(NAME_LENGTH)) begin
                        n_phase = PH_DATA;
                    end else begin
                        if (r_bits == '0) begin
                            load    = 1'b1;
                            ld_byte = name_byte(r_name);
                            n_name  = r_name + 1'b1;
                        end
                        run = 1'b1;
                    end
                end
                PH_DATA: begin
                    if (r_bits == '0 && !i_item.byte_available) begin
                        n_phase              = PH_DONE;
                        o_result.end_of_data = 1'b1;
                    end else begin
                        if (r_bits == '0) begin
                            load                = 1'b1;
                            ld_byte             = i_item.offered_byte;
                            o_result.byte_taken = 1'b1;
                        end
                        run = 1'b1;
                    end
                end
                PH_DONE: begin
                    o_result.end_of_data = 1'b1;
                end
                default: ;
            endcase
        end

        // bit writer: one half-period per tick
        w_shift  = load ? ld_byte : r_shift;
        w_bits   = load ? BIT_SLOTS : r_bits;
        w_pulses = load ? 5'd0 : r_pulses;
        if (run) begin
            o_result.period_valid = 1'b1;
            o_result.period = (w_pulses == PULSES_GAP) ? i_cfg.gap_period
                                                       : i_cfg.pulse_period;
            if (w_pulses == '0) begin
                // opening zero-length period of a new bit
                w_pulses        = w_shift[7] ? PULSES_ONE : PULSES_ZERO;
                w_shift         = {w_shift[6:0], 1'b0};
                w_bits          = w_bits - 1'b1;
                o_result.period = '0;
            end
            n_pulses = w_pulses - 1'b1;
            n_shift  = w_shift;
            n_bits   = w_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_name   <= '0;
            r_bits   <= '0;
            r_pulses <= '0;
            r_shift  <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_name   <= n_name;
            r_bits   <= n_bits;
            r_pulses <= n_pulses;
            r_shift  <= n_shift;
        end
    end

endmodule

>>> rtl/core/tape_bit_pulse_encoder_top.sv
// Tape bit pulse encoder. Each input item is one output tick: the block
// answers with one result item giving the next tape half-period (period,
// with period_valid), whether the offered data byte was consumed
// (byte_taken) and whether the source has run dry (end_of_data). Bytes go
// out MSB first; each bit opens with a zero-length period, a one bit then
// gives 17 pulse half-periods and a zero bit 7, and a gap period closes it.
// A fixed filename of NAME_LENGTH bytes may precede the data. Rate: one
// item per clock; the result is registered in the output register on
// acceptance, and the input stays open while that register is empty or
// being drained, so a sink that is always ready sees one result per cycle.
// Configuration writes are taken every cycle and must only be issued while
// no result is outstanding.
module tape_bit_pulse_encoder_top import tbpe_pkg::*; #(
    parameter int NAME_LENGTH = NAME_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbpe_in_if.sink    i_in,
    tbpe_out_if.source o_out,
    tbpe_cfg_if.sink   i_cfg
);

    // configuration registers
    t_cfg r_cfg;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    t_out_item result;
    logic      in_acc;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.with_filename <= 1'b1;
            r_cfg.pulse_period  <= PERIOD_W'(1);
            r_cfg.gap_period    <= PERIOD_W'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WITH_FILENAME: r_cfg.with_filename <= i_cfg.wdata[0];
                CFG_PULSE_PERIOD:  r_cfg.pulse_period  <= i_cfg.wdata;
                CFG_GAP_PERIOD:    r_cfg.gap_period    <= i_cfg.wdata;
                default: ; // unmapped index: write dropped
            endcase
        end
    end

    // take a tick whenever the output register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    tbpe_core #(
        .NAME_LENGTH (NAME_LENGTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_acc),
        .i_item   (i_in.data),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

>>> rtl/core/tbpe_checker.sv
module tbpe_checker import tbpe_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // finished ticks carry no period
    a_eod_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.end_of_data |->
            !i_out_data.period_valid && i_out_data.period == '0 &&
            !i_out_data.byte_taken)
        else $error("end_of_data item carries a period or a byte");

    // a byte load always opens with a zero-length period
    a_take_opens_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.byte_taken |->
            i_out_data.period_valid && i_out_data.period == '0)
        else $error("byte taken without opening zero period");

    // an accepted tick produces a result in the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted item produced no result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind tape_bit_pulse_encoder_top tbpe_checker u_tbpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

>>> dv/tape_bit_pulse_encoder_top_test.sv
module tape_bit_pulse_encoder_top_test import tbpe_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_LEN     = NAME_LENGTH_DEF;
    localparam int TAG_BYTES    = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 32;

    // fixed filename sent ahead of the data when with_filename is set
    localparam logic [7:0] FILE_TAG [TAG_BYTES] =
        '{"T", "Z", "X", "D", "U", "I", "N", "O", 8'h9D};

    logic i_clk;
    logic i_rst_n;

    tbpe_in_if  in_if ();
    tbpe_out_if out_if ();
    tbpe_cfg_if cfg_if ();

    tape_bit_pulse_encoder_top #(
        .NAME_LENGTH(NAME_LEN)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // ticks waiting to be driven, and the half-periods they must produce
    t_in_item  ticks_to_send [$];
    t_out_item periods_due [$];

    int unsigned mismatches;
    int unsigned cycle_count;
    bit          in_took;    // input item accepted at the last rising edge
    bit          calm;       // suppresses idling on both sides

    // shadow copy of the encoder: registers and sequencing state
    t_cfg       set_cfg         = '{with_filename: 1'b1, pulse_period: 16'd1, gap_period: 16'd1};
    t_phase     enc_phase       = PH_START;
    logic [3:0] enc_name_idx    = '0;
    logic [3:0] enc_bits_left   = '0;
    logic [4:0] enc_pulses_left = '0;
    logic [7:0] enc_shift       = '0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // One slot of the bit writer. A zero pulse count opens the next bit with a
    // zero-length period and reloads the count from the outgoing MSB; a count
    // of one means the closing gap.
    function automatic logic [15:0] next_half_period();
        logic [15:0] p;
        p = (enc_pulses_left == PULSES_GAP) ? set_cfg.gap_period : set_cfg.pulse_period;
        if (enc_pulses_left == 5'd0) begin
            enc_pulses_left = enc_shift[7] ? PULSES_ONE : PULSES_ZERO;
            enc_shift       = enc_shift << 1;
            enc_bits_left   = enc_bits_left - 4'd1;
            p               = '0;
        end
        enc_pulses_left = enc_pulses_left - 5'd1;
        return p;
    endfunction

    function automatic t_out_item encode_tick(input t_in_item it);
        t_out_item r;
        r = '0;
        if (it.start_req || enc_phase == PH_START) begin
            // start of a block: counters cleared, no period this tick
            enc_name_idx    = '0;
            enc_bits_left   = '0;
            enc_pulses_left = '0;
            enc_shift       = '0;
            enc_phase       = set_cfg.with_filename ? PH_NAME : PH_DATA;
        end else if (enc_phase == PH_NAME) begin
            if (enc_bits_left == 4'd0 && enc_name_idx >= NAME_LEN) begin
                enc_phase = PH_DATA;    // switch tick, nothing emitted
            end else begin
                if (enc_bits_left == 4'd0) begin
                    enc_shift       = (enc_name_idx < TAG_BYTES) ? FILE_TAG[enc_name_idx] : 8'h00;
                    enc_name_idx    = enc_name_idx + 4'd1;
                    enc_bits_left   = BIT_SLOTS;
                    enc_pulses_left = '0;
                end
                r.period       = next_half_period();
                r.period_valid = 1'b1;
            end
        end else if (enc_phase == PH_DATA) begin
            if (enc_bits_left == 4'd0 && !it.byte_available) begin
                enc_phase     = PH_DONE;
                r.end_of_data = 1'b1;
            end else begin
                if (enc_bits_left == 4'd0) begin
                    enc_shift       = it.offered_byte;
                    r.byte_taken    = 1'b1;
                    enc_bits_left   = BIT_SLOTS;
                    enc_pulses_left = '0;
                end
                r.period       = next_half_period();
                r.period_valid = 1'b1;
            end
        end else begin
            r.end_of_data = 1'b1;   // finished until the next start request
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Driver: one item per handshake, changed only at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_if.valid || in_took)) begin
            if (ticks_to_send.size() != 0 && !take_break()) begin
                in_if.data  <= ticks_to_send.pop_front();
                in_if.valid <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge i_clk) begin
        out_if.ready <= !take_break();
    end

    // Monitor: register writes, accepted ticks and accepted results, all
    // sampled at the rising edge. Results are checked before new ticks are
    // predicted; a result never comes out on the edge its tick went in.
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        in_took = 1'b0;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_WITH_FILENAME: set_cfg.with_filename = cfg_if.wdata[0];
                    CFG_PULSE_PERIOD:  set_cfg.pulse_period  = cfg_if.wdata;
                    CFG_GAP_PERIOD:    set_cfg.gap_period    = cfg_if.wdata;
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (periods_due.size() == 0) begin
                    $error("result with no tick outstanding: period %0d", got.period);
                    mismatches++;
                end else begin
                    want = periods_due.pop_front();
                    check_field("period", 32'(want.period), 32'(got.period));
                    check_field("period_valid", 32'(want.period_valid),
                                32'(got.period_valid));
                    check_field("byte_taken", 32'(want.byte_taken), 32'(got.byte_taken));
                    check_field("end_of_data", 32'(want.end_of_data),
                                32'(got.end_of_data));
                end
            end
            if (in_if.valid && in_if.ready) begin
                in_took = 1'b1;
                periods_due.push_back(encode_tick(in_if.data));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tape_bit_pulse_encoder_top: mismatch");
            $finish;
        end
    end

    task automatic push_tick(input bit start, input logic [7:0] byte_in, input bit avail);
        ticks_to_send.push_back(t_in_item'{start_req: start, offered_byte: byte_in,
                                           byte_available: avail});
    endtask

    // Block until every queued tick has gone in and its result has come back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (ticks_to_send.size() != 0 || in_if.valid || periods_due.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // Writes all three registers back to back; only called while idle.
    // Upper bits of the with_filename word are junk on purpose.
    task automatic apply_settings(input logic wf, input logic [15:0] pulse,
                                  input logic [15:0] gap);
        logic [CFG_DATA_W-1:0] vals [3];
        logic [CFG_IDX_W-1:0]  regs [3];
        vals = '{{15'($urandom), wf}, pulse, gap};
        regs = '{CFG_WITH_FILENAME, CFG_PULSE_PERIOD, CFG_GAP_PERIOD};
        for (int r = 0; r < 3; r++) begin
            @(negedge i_clk);
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[r];
            cfg_if.wdata <= vals[r];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Data-only traffic: mostly sessions that open with a start request and
    // then run with random bytes, the source dropping out now and then so
    // blocks finish; one session in ten is short random noise.
    task automatic queue_data_sessions(input int n);
        int  left;
        int  len;
        bit  noise;
        left = n;
        while (left > 0) begin
            noise = ($urandom_range(9) == 0);
            len   = noise ? $urandom_range(1, 4) : $urandom_range(20, 300);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++) begin
                if (noise)
                    push_tick(1'($urandom_range(1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                else
                    push_tick(k == 0, 8'($urandom_range(255)), $urandom_range(99) >= 25);
            end
            left -= len;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.data    = '0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.wdata  = '0;
        calm          = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings (filename on, unit periods). First tick
        // leaves the start phase on its own, then the opening bits of the
        // filename, a restart in the middle of it, and a fresh first tick.
        push_tick(1'b0, 8'h00, 1'b0);
        for (int k = 0; k < 10; k++)
            push_tick(1'b0, 8'($urandom), k[0]);
        push_tick(1'b1, 8'hFF, 1'b1);
        push_tick(1'b0, 8'h00, 1'b1);
        wait_idle();

        // Directed, data only with zero pulse and full-scale gap: immediate
        // end of data, finished ticks ignore the source, a start request
        // wins over an empty source, an MSB-only byte, a restart mid-bit.
        apply_settings(1'b0, 16'h0000, 16'hFFFF);
        push_tick(1'b1, 8'hFF, 1'b1);
        push_tick(1'b0, 8'hFF, 1'b0);
        push_tick(1'b0, 8'hA5, 1'b1);
        push_tick(1'b1, 8'h00, 1'b0);
        push_tick(1'b0, 8'h80, 1'b1);
        for (int k = 0; k < 5; k++)
            push_tick(1'b0, 8'h7F, 1'b1);
        push_tick(1'b1, 8'h55, 1'b1);
        push_tick(1'b0, 8'h00, 1'b1);
        wait_idle();

        // Most of the filename: the switch tick to the data lies past the last
        // tick queued here, so this run is one long uninterrupted block, driven
        // with no idling on either side.
        calm = 1'b1;
        apply_settings(1'b1, 16'hFFFF, 16'h0000);
        push_tick(1'b1, 8'($urandom), 1'b1);
        for (int k = 1; k < 1000; k++)
            push_tick(1'b0, 8'($urandom), $urandom_range(99) >= 10);
        wait_idle();
        calm = 1'b0;

        apply_settings(1'b0, 16'h0001, 16'hFFFF);
        queue_data_sessions(40);
        wait_idle();

        apply_settings(1'b0, 16'($urandom), 16'($urandom));
        queue_data_sessions(30);
        wait_idle();

        apply_settings(1'b0, 16'h0000, 16'($urandom));
        queue_data_sessions(30);
        wait_idle();

        // filename on but sessions are short, so mostly start and name ticks
        apply_settings(1'b1, 16'($urandom), 16'($urandom));
        queue_data_sessions(30);
        wait_idle();

        // let any stray result surface before the verdict
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && periods_due.size() == 0) begin
            $display("tape_bit_pulse_encoder_top: match");
        end else begin
            $display("tape_bit_pulse_encoder_top: mismatch");
        end
        $finish;
    end

endmodule
